FILE: src/ept_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ept_pkg
// Shared types, register map and helpers for the edge-aligned PWM timer.
// ----------------------------------------------------------------------------
package ept_pkg;

    localparam int COUNT_WIDTH = 16;   // counter, reload and compare width
    localparam int DATA_WIDTH  = 16;   // bus data width
    localparam int PSC_WIDTH   = 16;   // prescaler width, fixed
    localparam int EXT_WIDTH   = (COUNT_WIDTH > DATA_WIDTH) ? COUNT_WIDTH : DATA_WIDTH;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;
    typedef logic [DATA_WIDTH-1:0]  t_data;
    typedef logic [PSC_WIDTH-1:0]   t_psc;
    typedef logic [EXT_WIDTH-1:0]   t_ext;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register map
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_EVENT    = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OUT_EN   = 3'd3;
    localparam logic [2:0] REG_PRESCALE = 3'd4;
    localparam logic [2:0] REG_RELOAD   = 3'd5;
    localparam logic [2:0] REG_COMPARE  = 3'd6;
    localparam logic [2:0] REG_COUNT    = 3'd7;

    // register bit positions
    localparam int CEN_BIT = 0;
    localparam int UG_BIT  = 0;
    localparam int UIF_BIT = 0;
    localparam int CCE_BIT = 4;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] register_index;
        t_data      write_value;
    } t_item;

    typedef struct packed {
        t_data read_value;
        logic  pwm_level;
        logic  update_flag;
    } t_result;

    // bus data to counter width: zero-extend or truncate
    function automatic t_cnt data_to_cnt(input t_data v);
        t_ext tmp;
        tmp = t_ext'(v);
        return tmp[COUNT_WIDTH-1:0];
    endfunction

    // counter width to bus data: low bits only
    function automatic t_data cnt_to_data(input t_cnt v);
        t_ext tmp;
        tmp = t_ext'(v);
        return tmp[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/ept_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ept_in_stage
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module ept_in_stage
    import ept_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_item_valid,
    output t_item      o_item,
    input  wire logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // refill in the same cycle the held item leaves
    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: src/ept_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ept_core
// Timer state: prescaler, counter, shadow/live registers, flags. Applies one
// item per firing cycle and forms its result from the updated state.
// ----------------------------------------------------------------------------
module ept_core
    import ept_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_result
);

    t_psc r_psc_cnt,    n_psc_cnt;
    t_cnt r_cnt,        n_cnt;
    t_psc r_psc_shadow, n_psc_shadow;
    t_psc r_psc_live,   n_psc_live;
    t_cnt r_arr_shadow, n_arr_shadow;
    t_cnt r_arr_live,   n_arr_live;
    t_cnt r_ccr_shadow, n_ccr_shadow;
    t_cnt r_ccr_live,   n_ccr_live;
    logic r_cen,        n_cen;
    logic r_oe,         n_oe;
    logic r_sticky,     n_sticky;

    logic  upd;
    t_data rd;

    always_comb begin
        n_psc_cnt    = r_psc_cnt;
        n_cnt        = r_cnt;
        n_psc_shadow = r_psc_shadow;
        n_psc_live   = r_psc_live;
        n_arr_shadow = r_arr_shadow;
        n_arr_live   = r_arr_live;
        n_ccr_shadow = r_ccr_shadow;
        n_ccr_live   = r_ccr_live;
        n_cen        = r_cen;
        n_oe         = r_oe;
        n_sticky     = r_sticky;
        upd          = 1'b0;
        rd           = '0;

        case (i_item.operation)
            OP_TICK: begin
                if (r_cen) begin
                    if (r_psc_cnt >= r_psc_live) begin
                        n_psc_cnt = '0;
                        // >= so a count written above reload wraps too
                        if (r_cnt >= r_arr_live) begin
                            n_cnt = '0;
                            upd   = 1'b1;
                        end else begin
                            n_cnt = t_cnt'(r_cnt + 1'b1);
                        end
                    end else begin
                        n_psc_cnt = t_psc'(r_psc_cnt + 1'b1);
                    end
                end
            end
            OP_WRITE: begin
                unique case (i_item.register_index)
                    REG_CTRL:     n_cen = i_item.write_value[CEN_BIT];
                    REG_EVENT: begin
                        if (i_item.write_value[UG_BIT]) begin
                            n_psc_cnt = '0;
                            n_cnt     = '0;
                            upd       = 1'b1;
                        end
                    end
                    REG_STATUS: begin
                        if (!i_item.write_value[UIF_BIT]) begin
                            n_sticky = 1'b0;
                        end
                    end
                    REG_OUT_EN:   n_oe         = i_item.write_value[CCE_BIT];
                    REG_PRESCALE: n_psc_shadow = i_item.write_value;
                    REG_RELOAD:   n_arr_shadow = data_to_cnt(i_item.write_value);
                    REG_COMPARE:  n_ccr_shadow = data_to_cnt(i_item.write_value);
                    REG_COUNT:    n_cnt        = data_to_cnt(i_item.write_value);
                    default:      ;
                endcase
            end
            OP_READ: begin
                unique case (i_item.register_index)
                    REG_CTRL:     rd[CEN_BIT] = r_cen;
                    REG_EVENT:    rd = '0;
                    REG_STATUS:   rd[UIF_BIT] = r_sticky;
                    REG_OUT_EN:   rd[CCE_BIT] = r_oe;
                    REG_PRESCALE: rd = r_psc_shadow;
                    REG_RELOAD:   rd = cnt_to_data(r_arr_shadow);
                    REG_COMPARE:  rd = cnt_to_data(r_ccr_shadow);
                    REG_COUNT:    rd = cnt_to_data(r_cnt);
                    default:      rd = '0;
                endcase
            end
            default: ;
        endcase

        // update event: shadows go live, flag sets
        if (upd) begin
            n_psc_live = r_psc_shadow;
            n_arr_live = r_arr_shadow;
            n_ccr_live = r_ccr_shadow;
            n_sticky   = 1'b1;
        end
    end

    assign o_result.read_value  = rd;
    assign o_result.pwm_level   = n_oe && (n_cnt < n_ccr_live);
    assign o_result.update_flag = n_sticky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psc_cnt    <= '0;
            r_cnt        <= '0;
            r_psc_shadow <= '0;
            r_psc_live   <= '0;
            r_arr_shadow <= '1;
            r_arr_live   <= '1;
            r_ccr_shadow <= '0;
            r_ccr_live   <= '0;
            r_cen        <= 1'b0;
            r_oe         <= 1'b0;
            r_sticky     <= 1'b0;
        end else if (i_fire) begin
            r_psc_cnt    <= n_psc_cnt;
            r_cnt        <= n_cnt;
            r_psc_shadow <= n_psc_shadow;
            r_psc_live   <= n_psc_live;
            r_arr_shadow <= n_arr_shadow;
            r_arr_live   <= n_arr_live;
            r_ccr_shadow <= n_ccr_shadow;
            r_ccr_live   <= n_ccr_live;
            r_cen        <= n_cen;
            r_oe         <= n_oe;
            r_sticky     <= n_sticky;
        end
    end

    a_forced_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.operation == OP_WRITE && i_item.register_index == REG_EVENT
        && i_item.write_value[UG_BIT]
        |=> r_cnt == '0 && r_psc_cnt == '0 && r_sticky
            && r_arr_live == $past(r_arr_shadow) && r_ccr_live == $past(r_ccr_shadow))
        else $error("forced update did not reload live registers");

    a_tick_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.operation == OP_TICK && !r_cen
        |=> $stable(r_cnt) && $stable(r_psc_cnt) && $stable(r_sticky))
        else $error("counter moved while disabled");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_fire)
        |-> $stable(r_cnt) && $stable(r_psc_cnt) && $stable(r_sticky) && $stable(r_ccr_live))
        else $error("state changed without an item");

    a_live_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_ccr_live != $past(r_ccr_live) || r_arr_live != $past(r_arr_live))
        |-> r_sticky)
        else $error("live register changed without update event");

endmodule
`default_nettype wire

FILE: src/ept_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ept_out_stage
// Result register: holds one finished item result until the sink takes it.
// ----------------------------------------------------------------------------
module ept_out_stage
    import ept_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load_valid,
    output logic         o_can_load,
    input  wire t_result i_result,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_valid) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

FILE: src/edge_aligned_pwm_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_aligned_pwm_timer
// Up-counting timer with one edge-aligned PWM channel, driven by tick,
// register write and register read items.
// ----------------------------------------------------------------------------
// Every item produces exactly one result. The block takes one item per clock
// cycle with no bubbles while the result side keeps up: an item is held in the
// input register, is applied to the timer state in a single pass of logic,
// and its result is loaded into the result register once that register can
// take it. Throughput is set by the core's state update, done in a single pass
// of logic; back-pressure on the result side stalls input only once both
// registers are full.
// ----------------------------------------------------------------------------
module edge_aligned_pwm_timer
    import ept_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [2:0]  i_register_index,
    input  wire logic [15:0] i_write_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_read_value,
    output logic             o_pwm_level,
    output logic             o_update_flag
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    can_load;
    logic    fire;
    t_result core_result;
    t_result out_result;

    assign in_item.operation      = i_operation;
    assign in_item.register_index = i_register_index;
    assign in_item.write_value    = i_write_value;

    assign fire = held_valid && can_load;

    ept_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_take       (fire)
    );

    ept_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (core_result)
    );

    ept_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (held_valid),
        .o_can_load   (can_load),
        .i_result     (core_result),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (out_result)
    );

    assign o_read_value  = out_result.read_value;
    assign o_pwm_level   = out_result.pwm_level;
    assign o_update_flag = out_result.update_flag;

endmodule
`default_nettype wire
